>>> src/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types, constants and twiddle tables of the radix-2 complex FFT unit.
// ----------------------------------------------------------------------------
`default_nettype none
package r2fft_pkg;

	localparam int LOG2_MAX = 10;
	localparam int NPTS = 1 << LOG2_MAX;
	localparam int SAMPLE_BITS = 16;
	localparam int WORD_BITS = 26;
	localparam int PROD_BITS = SAMPLE_BITS + WORD_BITS;
	localparam int ACC_BITS = PROD_BITS + 1;
	localparam int TW_DEPTH = NPTS / 4;

	localparam logic [1:0] REG_LOG2_SIZE = 2'd0;
	localparam logic [1:0] REG_INVERSE = 2'd1;

	typedef logic [15:0] tab_t [TW_DEPTH];

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PULL,
		ST_RD_J,
		ST_RD_M,
		ST_LATCH,
		ST_MUL,
		ST_ADD,
		ST_WR_J,
		ST_WR_M,
		ST_SC_RD,
		ST_SC_WR
	} state_t;

	function automatic tab_t gen_tab(input bit use_sin);
		tab_t t;
		real ang;
		real v;
		int q;
		for (int r = 0; r < TW_DEPTH; r++) begin
			ang = 1.5707963267948966 * r / TW_DEPTH;
			v = (use_sin ? $sin(ang) : $cos(ang)) * 32768.0 + 0.5;
			if (v < 0.0) v = 0.0;
			q = $rtoi(v);
			if (q > 32767) q = 32767;
			t[r] = 16'(q);
		end
		return t;
	endfunction

	localparam tab_t COS_TAB = gen_tab(1'b0);
	localparam tab_t SIN_TAB = gen_tab(1'b1);

endpackage
`default_nettype wire

>>> src/radix2_complex_fft_unit.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft_unit
// Iterative in-place radix-2 DIT FFT over a 1024-word sample memory.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry req_type: 0 pushes one Q1.15 sample,
// 1 pulls the next bin. A pull yields one result word on res_valid/res_ready;
// a push yields none. A pull of a ready frame goes via rd_q and ST_PULL to the
// result register; other pulls register a result with out_valid low directly.
// The push that completes a frame starts the transform: each butterfly steps
// through read, latch, multiply, add and write states on the shared multiplier
// and the sample memory; inverse mode adds a pass scaling all N points.
// in_ready is low in ST_PULL, during the transform and while a result waits in
// the output register; a stalled receiver holds the block. Reset clears the
// counters and selects a forward 1024-point transform; the sample memory is
// not cleared. A write to the size or inverse register abandons the frame.
// ----------------------------------------------------------------------------
`default_nettype none
module radix2_complex_fft_unit
	import r2fft_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [3:0]             cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   req_type,
	input  wire logic signed [15:0]     in_real,
	input  wire logic signed [15:0]     in_imag,
	output logic                        res_valid,
	input  wire logic                   res_ready,
	output logic                        out_valid,
	output logic [9:0]                  out_index,
	output logic signed [25:0]          out_real,
	output logic signed [25:0]          out_imag,
	output logic                        out_last
);

	localparam int AW = LOG2_MAX;

	state_t state_q, state_d;
	logic [3:0] log2_q;
	logic inv_q;
	logic [AW:0] load_q, read_q;
	logic frame_q;
	logic resv_q;

	logic [2*WORD_BITS-1:0] mem [NPTS];
	logic [2*WORD_BITS-1:0] rd_q;
	logic [AW-1:0] raddr, waddr;
	logic [2*WORD_BITS-1:0] wdata;
	logic we;

	logic [3:0] stage_q;
	logic [AW-2:0] bf_q;
	logic [AW-1:0] cnt_q;
	logic [2:0] ph_q;
	logic signed [WORD_BITS-1:0] xjr_q, xji_q, xmr_q, xmi_q;
	logic signed [15:0] wr_q, wi_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [ACC_BITS-1:0] accr_q, acci_q;
	logic signed [WORD_BITS-1:0] yjr_q, yji_q, ymr_q, ymi_q;

	logic [3:0] l_eff;
	logic [AW:0] n_pts;
	logic push_acc, pull_acc;
	logic [AW:0] lc_eff;
	logic [AW-1:0] rev_full, push_addr;
	logic [AW-1:0] half, kmask, j_addr, m_addr;
	logic [AW-2:0] tw_idx;
	logic [7:0] tw_r;
	logic signed [15:0] tc, ts, tw_re, tw_im;
	logic signed [15:0] mul_a;
	logic signed [WORD_BITS-1:0] mul_b;
	logic signed [ACC_BITS-16:0] tr, ti;
	logic signed [ACC_BITS-14:0] sjr, sji, smr, smi;
	logic last_bf, last_stage;
	logic pull_hit;
	logic signed [WORD_BITS-1:0] sc_r, sc_i;

	function automatic logic signed [WORD_BITS-1:0] sat(input logic signed [ACC_BITS-14:0] v);
		logic signed [ACC_BITS-14:0] hi, lo;
		hi = (ACC_BITS-13)'((1 << (WORD_BITS - 1)) - 1);
		lo = ~hi;
		if (v > hi) return hi[WORD_BITS-1:0];
		if (v < lo) return lo[WORD_BITS-1:0];
		return v[WORD_BITS-1:0];
	endfunction

	always_comb begin
		l_eff = log2_q;
		if (log2_q < 4'd1) l_eff = 4'd1;
		if (log2_q > 4'(LOG2_MAX)) l_eff = 4'(LOG2_MAX);
		n_pts = (AW+1)'(1) << l_eff;
	end

	assign in_ready = (state_q == ST_IDLE) && !resv_q;
	assign push_acc = in_valid && in_ready && !req_type;
	assign pull_acc = in_valid && in_ready && req_type;
	assign pull_hit = frame_q && (read_q < n_pts);

	always_comb begin
		lc_eff = (frame_q || load_q >= n_pts) ? '0 : load_q;
		for (int i = 0; i < AW; i++) rev_full[i] = lc_eff[AW-1-i];
		push_addr = rev_full >> (4'(LOG2_MAX) - l_eff);
	end

	always_comb begin
		half = AW'(1) << (stage_q - 4'd1);
		kmask = half - AW'(1);
		j_addr = ({1'b0, bf_q} & kmask) | (({1'b0, bf_q} & ~kmask) << 1);
		m_addr = j_addr | half;
		tw_idx = (AW-1)'(j_addr & kmask) << (4'(LOG2_MAX) - stage_q);
		tw_r = tw_idx[7:0];
		tc = $signed(COS_TAB[tw_r]);
		ts = $signed(SIN_TAB[tw_r]);
		tw_re = tw_idx[AW-2] ? -ts : tc;
		tw_im = tw_idx[AW-2] ? tc : ts;
		last_bf = (bf_q == (AW-1)'((n_pts >> 1) - (AW+1)'(1)));
		last_stage = (stage_q == l_eff);
	end

	always_comb begin
		unique case (ph_q)
			3'd0: begin mul_a = wr_q; mul_b = xmr_q; end
			3'd1: begin mul_a = wi_q; mul_b = xmi_q; end
			3'd2: begin mul_a = wr_q; mul_b = xmi_q; end
			default: begin mul_a = wi_q; mul_b = xmr_q; end
		endcase
	end

	always_comb begin
		tr = accr_q[ACC_BITS-1:15];
		ti = acci_q[ACC_BITS-1:15];
		sjr = (ACC_BITS-13)'(xjr_q) + (ACC_BITS-13)'(tr);
		sji = (ACC_BITS-13)'(xji_q) + (ACC_BITS-13)'(ti);
		smr = (ACC_BITS-13)'(xjr_q) - (ACC_BITS-13)'(tr);
		smi = (ACC_BITS-13)'(xji_q) - (ACC_BITS-13)'(ti);
		sc_r = $signed(rd_q[2*WORD_BITS-1:WORD_BITS]) >>> l_eff;
		sc_i = $signed(rd_q[WORD_BITS-1:0]) >>> l_eff;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pull_acc && pull_hit) state_d = ST_PULL;
				else if (push_acc && (lc_eff + (AW+1)'(1) == n_pts)) state_d = ST_RD_J;
			end
			ST_PULL: state_d = ST_IDLE;
			ST_RD_J: state_d = ST_RD_M;
			ST_RD_M: state_d = ST_LATCH;
			ST_LATCH: state_d = ST_MUL;
			ST_MUL: if (ph_q == 3'd4) state_d = ST_ADD;
			ST_ADD: state_d = ST_WR_J;
			ST_WR_J: state_d = ST_WR_M;
			ST_WR_M: begin
				if (!last_bf || !last_stage) state_d = ST_RD_J;
				else if (inv_q) state_d = ST_SC_RD;
				else state_d = ST_IDLE;
			end
			ST_SC_RD: state_d = ST_SC_WR;
			ST_SC_WR: state_d = (cnt_q == AW'(n_pts - (AW+1)'(1))) ? ST_IDLE : ST_SC_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		we = 1'b0;
		waddr = push_addr;
		wdata = {(WORD_BITS)'(in_real), (WORD_BITS)'(in_imag)};
		raddr = read_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: we = push_acc;
			ST_RD_J: raddr = j_addr;
			ST_RD_M: raddr = m_addr;
			ST_WR_J: begin we = 1'b1; waddr = j_addr; wdata = {yjr_q, yji_q}; end
			ST_WR_M: begin we = 1'b1; waddr = m_addr; wdata = {ymr_q, ymi_q}; end
			ST_SC_RD: raddr = cnt_q;
			ST_SC_WR: begin we = 1'b1; waddr = cnt_q; wdata = {sc_r, sc_i}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			log2_q <= 4'(LOG2_MAX);
			inv_q <= 1'b0;
			load_q <= '0;
			read_q <= '0;
			frame_q <= 1'b0;
			resv_q <= 1'b0;
			stage_q <= 4'd1;
			bf_q <= '0;
			cnt_q <= '0;
			ph_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid && res_ready) resv_q <= 1'b0;
			if (cfg_we && (cfg_index == REG_LOG2_SIZE || cfg_index == REG_INVERSE)) begin
				if (cfg_index == REG_LOG2_SIZE) log2_q <= cfg_data;
				else inv_q <= cfg_data[0];
				load_q <= '0;
				read_q <= '0;
				frame_q <= 1'b0;
			end
			if (push_acc) begin
				frame_q <= 1'b0;
				read_q <= '0;
				load_q <= (lc_eff + (AW+1)'(1) == n_pts) ? '0 : lc_eff + (AW+1)'(1);
				stage_q <= 4'd1;
				bf_q <= '0;
				cnt_q <= '0;
			end
			if (pull_acc) begin
				if (!pull_hit) resv_q <= 1'b1;
			end
			if (state_q == ST_PULL) begin
				resv_q <= 1'b1;
				if (read_q + (AW+1)'(1) == n_pts) begin
					read_q <= '0;
					frame_q <= 1'b0;
				end else begin
					read_q <= read_q + (AW+1)'(1);
				end
			end
			if (state_q == ST_LATCH) ph_q <= '0;
			if (state_q == ST_MUL) ph_q <= ph_q + 3'd1;
			if (state_q == ST_WR_M) begin
				if (last_bf) begin
					bf_q <= '0;
					stage_q <= stage_q + 4'd1;
					if (last_stage && !inv_q) frame_q <= 1'b1;
				end else begin
					bf_q <= bf_q + (AW-1)'(1);
				end
			end
			if (state_q == ST_SC_WR) begin
				cnt_q <= cnt_q + AW'(1);
				if (cnt_q == AW'(n_pts - (AW+1)'(1))) frame_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_J) begin
			wr_q <= tw_re;
			wi_q <= inv_q ? -tw_im : tw_im;
		end
		if (state_q == ST_RD_M) begin
			xjr_q <= $signed(rd_q[2*WORD_BITS-1:WORD_BITS]);
			xji_q <= $signed(rd_q[WORD_BITS-1:0]);
		end
		if (state_q == ST_LATCH) begin
			xmr_q <= $signed(rd_q[2*WORD_BITS-1:WORD_BITS]);
			xmi_q <= $signed(rd_q[WORD_BITS-1:0]);
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			unique case (ph_q)
				3'd1: accr_q <= ACC_BITS'(prod_q);
				3'd2: accr_q <= accr_q - ACC_BITS'(prod_q);
				3'd3: acci_q <= ACC_BITS'(prod_q);
				3'd4: acci_q <= acci_q + ACC_BITS'(prod_q);
				default: ;
			endcase
		end
		if (state_q == ST_ADD) begin
			yjr_q <= sat(sjr);
			yji_q <= sat(sji);
			ymr_q <= sat(smr);
			ymi_q <= sat(smi);
		end
		if (pull_acc) begin
			out_valid <= 1'b0;
			out_index <= '0;
			out_real <= '0;
			out_imag <= '0;
			out_last <= 1'b0;
		end
		if (state_q == ST_PULL) begin
			out_valid <= 1'b1;
			out_index <= read_q[AW-1:0];
			out_real <= $signed(rd_q[2*WORD_BITS-1:WORD_BITS]);
			out_imag <= $signed(rd_q[WORD_BITS-1:0]);
			out_last <= (read_q + (AW+1)'(1) == n_pts);
		end
	end

	assign res_valid = resv_q;

endmodule
`default_nettype wire
